### hw/rtl/evema_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Encoder velocity package
// Shared types and constants of the encoder velocity block with averaging.
// ---------------------------------------------------------------------------
package evema_pkg;

   localparam logic [25:0] USEC_PER_MIN = 26'd60000000;
   localparam logic [16:0] GAIN_ONE     = 17'd65536;
   localparam logic [15:0] CPR_RESET    = 16'd400;
   localparam logic [16:0] GAIN_RESET   = 17'd10486;
   localparam logic [47:0] POS_LIMIT    = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] NEG_LIMIT    = 48'h8000_0000_0000;

   localparam logic [0:0] CSR_COUNTS_PER_REV = 1'd0;
   localparam logic [0:0] CSR_FILTER_GAIN    = 1'd1;

   typedef struct packed {
      logic [62:0]        time_us;
      logic signed [31:0] encoder_count;
   } evema_req_type;

   typedef struct packed {
      logic signed [47:0] raw_rpm;
      logic signed [47:0] filtered_rpm;
   } evema_rsp_type;

   typedef enum logic [1:0] {
      KIND_FIRST,
      KIND_ZERO,
      KIND_SPEED
   } evema_kind_type;

   typedef struct packed {
      evema_kind_type kind;
      logic           neg;
      logic [31:0]    mag;
      logic [62:0]    dt;
   } evema_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_CHECK,
      ST_DIV,
      ST_SAT,
      ST_EMA_MUL,
      ST_EMA_ADD,
      ST_OUT
   } evema_state_type;

endpackage
`default_nettype wire

### hw/rtl/evema_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Encoder velocity front end
// Takes input beats, keeps the reference count and time, and classifies
// each beat into a work entry for the back end.
// ---------------------------------------------------------------------------
module evema_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_push,
   input  evema_pkg::evema_req_type req_data,
   input  wire                      q_full,
   output logic                     q_push,
   output evema_pkg::evema_entry_type q_entry
);

   logic [31:0] prev_count_ff, prev_count_in;
   logic [62:0] prev_time_ff, prev_time_in;
   logic        ref_taken_ff, ref_taken_in;
   logic [31:0] delta;

   always_comb begin
      q_push        = req_push && !q_full;
      delta         = req_data.encoder_count - prev_count_ff;
      q_entry.neg   = delta[31];
      q_entry.mag   = delta[31] ? (~delta + 32'd1) : delta;
      q_entry.dt    = req_data.time_us - prev_time_ff;
      if (!ref_taken_ff) begin
         q_entry.kind = evema_pkg::KIND_FIRST;
      end else if (req_data.time_us > prev_time_ff) begin
         q_entry.kind = evema_pkg::KIND_SPEED;
      end else begin
         q_entry.kind = evema_pkg::KIND_ZERO;
      end
      prev_count_in = prev_count_ff;
      prev_time_in  = prev_time_ff;
      ref_taken_in  = ref_taken_ff;
      if (q_push) begin
         prev_count_in = req_data.encoder_count;
         prev_time_in  = req_data.time_us;
         ref_taken_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
         prev_time_ff  <= '0;
         ref_taken_ff  <= 1'b0;
      end else begin
         prev_count_ff <= prev_count_in;
         prev_time_ff  <= prev_time_in;
         ref_taken_ff  <= ref_taken_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/evema_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Encoder velocity work queue
// Two-entry queue of classified work entries between front and back end.
// ---------------------------------------------------------------------------
module evema_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  evema_pkg::evema_entry_type push_entry,
   input  wire                        pop,
   output logic                       full,
   output logic                       empty,
   output evema_pkg::evema_entry_type head
);

   evema_pkg::evema_entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   always_comb begin
      full      = count_ff == 2'd2;
      empty     = count_ff == 2'd0;
      head      = slot_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/evema_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Encoder velocity back end
// Scales the count delta, divides by dt * counts_per_rev one quotient bit per
// cycle, saturates, updates the moving average and holds the result beat.
// ---------------------------------------------------------------------------
module evema_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        q_empty,
   input  evema_pkg::evema_entry_type q_head,
   output logic                       q_pop,
   input  wire  [15:0]                counts_per_rev,
   input  wire  [16:0]                filter_gain,
   output logic                       rsp_empty,
   input  wire                        rsp_pop,
   output evema_pkg::evema_rsp_type   rsp_data
);

   evema_pkg::evema_state_type state_ff, state_in;
   evema_pkg::evema_kind_type  kind_ff, kind_in;
   evema_pkg::evema_rsp_type   rsp_data_ff, rsp_data_in;

   logic        neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic [62:0] dt_ff, dt_in;
   logic [73:0] num_ff, num_in;
   logic [78:0] den_ff, den_in;
   logic [78:0] rem_ff, rem_in;
   logic [47:0] quot_ff, quot_in;
   logic        big_ff, big_in;
   logic [5:0]  count_ff, count_in;
   logic [47:0] raw_ff, raw_in;
   logic [66:0] prod_ff, prod_in;
   logic [47:0] avg_ff, avg_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [15:0] cpr_eff;
   logic [16:0] gain_eff;
   logic [57:0] num_mul;
   logic [47:0] den_lo;
   logic [46:0] den_hi;
   logic [79:0] trial;
   logic [79:0] trial_sub;
   logic        trial_ge;
   logic signed [48:0] diff;
   logic signed [66:0] ema_mul;

   always_comb begin
      cpr_eff   = (counts_per_rev == 16'd0) ? 16'd1 : counts_per_rev;
      gain_eff  = (filter_gain > evema_pkg::GAIN_ONE) ? evema_pkg::GAIN_ONE : filter_gain;
      num_mul   = mag_ff * evema_pkg::USEC_PER_MIN;
      den_lo    = dt_ff[31:0] * cpr_eff;
      den_hi    = dt_ff[62:32] * cpr_eff;
      trial     = {rem_ff, num_ff[47]};
      trial_ge  = trial >= {1'b0, den_ff};
      trial_sub = trial - {1'b0, den_ff};
      diff      = $signed({raw_ff[47], raw_ff}) - $signed({avg_ff[47], avg_ff});
      ema_mul   = diff * $signed({1'b0, gain_eff});
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      dt_in        = dt_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      big_in       = big_ff;
      count_in     = count_ff;
      raw_in       = raw_ff;
      prod_in      = prod_ff;
      avg_in       = avg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      q_pop        = 1'b0;

      unique case (state_ff)
         evema_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               kind_in = q_head.kind;
               neg_in  = q_head.neg;
               mag_in  = q_head.mag;
               dt_in   = q_head.dt;
               raw_in  = '0;
               unique case (q_head.kind)
                  evema_pkg::KIND_FIRST: state_in = evema_pkg::ST_OUT;
                  evema_pkg::KIND_ZERO:  state_in = evema_pkg::ST_EMA_MUL;
                  default:               state_in = evema_pkg::ST_MUL_LO;
               endcase
            end
         end
         evema_pkg::ST_MUL_LO: begin
            num_in   = {num_mul, 16'd0};
            den_in   = {31'd0, den_lo};
            state_in = evema_pkg::ST_MUL_HI;
         end
         evema_pkg::ST_MUL_HI: begin
            den_in   = den_ff + {den_hi, 32'd0};
            state_in = evema_pkg::ST_CHECK;
         end
         evema_pkg::ST_CHECK: begin
            big_in   = {53'd0, num_ff[73:48]} >= den_ff;
            rem_in   = {53'd0, num_ff[73:48]};
            count_in = '0;
            state_in = ({53'd0, num_ff[73:48]} >= den_ff) ? evema_pkg::ST_SAT
                                                          : evema_pkg::ST_DIV;
         end
         evema_pkg::ST_DIV: begin
            rem_in   = trial_ge ? trial_sub[78:0] : trial[78:0];
            quot_in  = {quot_ff[46:0], trial_ge};
            num_in   = {num_ff[72:0], 1'b0};
            count_in = count_ff + 6'd1;
            if (count_ff == 6'd47) begin
               state_in = evema_pkg::ST_SAT;
            end
         end
         evema_pkg::ST_SAT: begin
            if (neg_ff) begin
               raw_in = (big_ff || quot_ff > evema_pkg::NEG_LIMIT) ? evema_pkg::NEG_LIMIT
                                                                   : (~quot_ff + 48'd1);
            end else begin
               raw_in = (big_ff || quot_ff[47]) ? evema_pkg::POS_LIMIT : quot_ff;
            end
            state_in = evema_pkg::ST_EMA_MUL;
         end
         evema_pkg::ST_EMA_MUL: begin
            prod_in  = ema_mul;
            state_in = evema_pkg::ST_EMA_ADD;
         end
         evema_pkg::ST_EMA_ADD: begin
            avg_in   = avg_ff + prod_ff[63:16];
            state_in = evema_pkg::ST_OUT;
         end
         evema_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.raw_rpm      = raw_ff;
               rsp_data_in.filtered_rpm = (kind_ff == evema_pkg::KIND_FIRST) ? '0 : avg_ff;
               state_in                 = evema_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = evema_pkg::ST_IDLE;
         end
      endcase

      rsp_empty = !rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= evema_pkg::ST_IDLE;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      dt_ff       <= dt_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      big_ff      <= big_in;
      count_ff    <= count_in;
      raw_ff      <= raw_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

### hw/rtl/encoder_velocity_ema.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Encoder velocity with exponential moving average
// Each request beat carries a microsecond timestamp and an encoder count.
// Each response beat carries the raw speed and the averaged speed in rpm,
// both signed Q32.16, one response for every request in request order.
// Requests are pushed while req_full is low; responses are popped while
// rsp_empty is low. The csr port writes counts_per_rev and filter_gain and
// must be used only while the block is idle; the block does not enforce this.
// A front end classifies requests into a two-entry queue; the back end
// handles one entry at a time. A speed entry goes through the multiply,
// check, 48-step restoring divider, saturation and averaging states, and
// skips the divider when the quotient saturates; the first beat after reset
// goes straight to output and a beat with a non-increasing time to averaging.
// Reset clears the reference, the average, the work queue and the held
// response, and sets counts_per_rev to 400 and filter_gain to 10486.
// When the receiver stalls, the finished response is held, the back end
// waits, the queue fills and req_full rises after two more requests.
// ---------------------------------------------------------------------------
module encoder_velocity_ema (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_push,
   output logic                      req_full,
   input  evema_pkg::evema_req_type  req_data,
   output logic                      rsp_empty,
   input  wire                       rsp_pop,
   output evema_pkg::evema_rsp_type  rsp_data,
   input  wire                       csr_write,
   input  wire  [0:0]                csr_index,
   input  wire  [16:0]               csr_data
);

   logic [15:0] cpr_ff, cpr_in;
   logic [16:0] gain_ff, gain_in;

   logic                       q_push;
   logic                       q_pop;
   logic                       q_full;
   logic                       q_empty;
   evema_pkg::evema_entry_type q_entry;
   evema_pkg::evema_entry_type q_head;

   always_comb begin
      cpr_in  = cpr_ff;
      gain_in = gain_ff;
      if (csr_write) begin
         unique case (csr_index)
            evema_pkg::CSR_COUNTS_PER_REV: cpr_in  = csr_data[15:0];
            evema_pkg::CSR_FILTER_GAIN:    gain_in = csr_data;
            default: ;
         endcase
      end
      req_full = q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff  <= evema_pkg::CPR_RESET;
         gain_ff <= evema_pkg::GAIN_RESET;
      end else begin
         cpr_ff  <= cpr_in;
         gain_ff <= gain_in;
      end
   end

   evema_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   evema_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   evema_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .counts_per_rev (cpr_ff),
      .filter_gain    (gain_ff),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data)
   );

endmodule
`default_nettype wire

### dv/encoder_velocity_ema_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Encoder velocity with averaging: self-checking testbench
// Pushes timestamp and count beats into the block, predicts each response
// with an independent speed and moving-average tracker, and compares every
// popped response field by field. Directed beats cover the corner cases and
// register extremes, then random motion runs under several register settings
// with random idling on both sides in all but one setting.
// ---------------------------------------------------------------------------
module encoder_velocity_ema_tb;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   evema_pkg::evema_req_type req_data = '0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   evema_pkg::evema_rsp_type rsp_data;
   logic                    csr_write = 1'b0;
   logic [0:0]              csr_index = evema_pkg::CSR_COUNTS_PER_REV;
   logic [16:0]             csr_data = '0;

   evema_pkg::evema_rsp_type pending_speeds[$];
   evema_pkg::evema_rsp_type wanted;
   int                 failures = 0;
   bit                 no_gaps = 1'b0;

   logic [15:0]        rev_counts = evema_pkg::CPR_RESET;
   logic [16:0]        ema_gain = evema_pkg::GAIN_RESET;
   logic [31:0]        last_count = '0;
   logic [62:0]        last_stamp = '0;
   logic signed [63:0] smoothed = '0;
   bit                 have_reference = 1'b0;

   encoder_velocity_ema dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $time, msg);
   endfunction

   function automatic evema_pkg::evema_rsp_type track_sample(
      input evema_pkg::evema_req_type s);
      evema_pkg::evema_rsp_type r;
      logic [31:0]        delta;
      logic [32:0]        mag;
      logic [127:0]       num;
      logic [127:0]       den;
      logic [127:0]       quo;
      logic [15:0]        cpr;
      logic [16:0]        g;
      logic signed [63:0] raw;
      logic signed [63:0] diff;
      logic signed [81:0] step;
      r = '0;
      if (!have_reference) begin
         have_reference = 1'b1;
         last_count = s.encoder_count;
         last_stamp = s.time_us;
         return r;
      end
      raw = '0;
      if (s.time_us > last_stamp) begin
         delta = s.encoder_count - last_count;
         mag = delta[31] ? {1'b0, ~delta} + 33'd1 : {1'b0, delta};
         num = 128'(mag);
         num = (num * 128'(evema_pkg::USEC_PER_MIN)) << 16;
         cpr = (rev_counts == 16'd0) ? 16'd1 : rev_counts;
         den = 128'(s.time_us - last_stamp);
         den = den * 128'(cpr);
         quo = num / den;
         if (delta[31]) begin
            if (quo > 128'(evema_pkg::NEG_LIMIT)) quo = 128'(evema_pkg::NEG_LIMIT);
            raw = 64'sd0 - $signed(quo[63:0]);
         end else begin
            if (quo > 128'(evema_pkg::POS_LIMIT)) quo = 128'(evema_pkg::POS_LIMIT);
            raw = $signed(quo[63:0]);
         end
      end
      g = (ema_gain > evema_pkg::GAIN_ONE) ? evema_pkg::GAIN_ONE : ema_gain;
      diff = raw - smoothed;
      step = 82'(diff) * 82'($signed({1'b0, g}));
      smoothed = smoothed + 64'(step >>> 16);
      last_count = s.encoder_count;
      last_stamp = s.time_us;
      r.raw_rpm = raw[47:0];
      r.filtered_rpm = smoothed[47:0];
      return r;
   endfunction

   always @(negedge clock) begin
      rsp_pop <= no_gaps || ($urandom_range(99) >= 36);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_speeds.size() == 0) begin
            note_failure($sformatf("unexpected response raw %h filtered %h",
                                   rsp_data.raw_rpm, rsp_data.filtered_rpm));
         end else begin
            wanted = pending_speeds.pop_front();
            if (rsp_data.raw_rpm !== wanted.raw_rpm)
               note_failure($sformatf("raw_rpm expected %h actual %h",
                                      wanted.raw_rpm, rsp_data.raw_rpm));
            if (rsp_data.filtered_rpm !== wanted.filtered_rpm)
               note_failure($sformatf("filtered_rpm expected %h actual %h",
                                      wanted.filtered_rpm, rsp_data.filtered_rpm));
         end
      end
   end

   task automatic send_sample(input logic [62:0] stamp, input logic [31:0] count);
      evema_pkg::evema_req_type s;
      s.time_us = stamp;
      s.encoder_count = count;
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < 36) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pending_speeds.push_back(track_sample(s));
   endtask

   // Holds the sender off until every response has been popped, then lets
   // the back end settle before any register write.
   task automatic drain;
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_speeds.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] index, input logic [16:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == evema_pkg::CSR_COUNTS_PER_REV) rev_counts = value[15:0];
      else if (index == evema_pkg::CSR_FILTER_GAIN) ema_gain = value;
   endtask

   task automatic test_corner_beats;
      send_sample(63'd1000, 32'd0);
      send_sample(63'd2000, 32'd400);
      send_sample(63'd3000, 32'd0);
      send_sample(63'd3000, 32'd100);
      send_sample(63'd2500, 32'd50);
      send_sample(63'd2501, 32'h7FFF_FFFF);
      send_sample(63'd2502, 32'h8000_0000);
      send_sample(63'd2503, 32'd0);
      send_sample({63{1'b1}}, 32'd5);
      send_sample(63'd0, 32'hFFFF_FFFB);
      send_sample(63'd1, 32'h7FFF_FFFF);
      send_sample(63'd2, 32'h7FFF_FFFE);
      drain();
   endtask

   task automatic test_register_extremes;
      write_csr(evema_pkg::CSR_COUNTS_PER_REV, 17'd0);
      write_csr(evema_pkg::CSR_FILTER_GAIN, 17'h1FFFF);
      send_sample(63'd10, 32'd1000);
      send_sample(63'd20, 32'hFFFF_F000);
      drain();
      write_csr(evema_pkg::CSR_COUNTS_PER_REV, 17'd65535);
      write_csr(evema_pkg::CSR_FILTER_GAIN, 17'd0);
      send_sample(63'd30, 32'd70000);
      send_sample(63'd31, 32'd0);
      drain();
      write_csr(evema_pkg::CSR_COUNTS_PER_REV, 17'd1);
      write_csr(evema_pkg::CSR_FILTER_GAIN, evema_pkg::GAIN_ONE);
      send_sample(63'd1000000, 32'd3);
      send_sample(63'd1000001, 32'h8000_0003);
      drain();
   endtask

   task automatic test_random_motion;
      logic [62:0] stamp;
      logic [31:0] count;
      int          pick;
      stamp = 63'($urandom_range(100000));
      count = $urandom;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               write_csr(evema_pkg::CSR_COUNTS_PER_REV, 17'd1);
               write_csr(evema_pkg::CSR_FILTER_GAIN, evema_pkg::GAIN_ONE);
            end
            1: begin
               write_csr(evema_pkg::CSR_COUNTS_PER_REV, 17'd65535);
               write_csr(evema_pkg::CSR_FILTER_GAIN, 17'd0);
            end
            2: begin
               write_csr(evema_pkg::CSR_COUNTS_PER_REV, 17'(evema_pkg::CPR_RESET));
               write_csr(evema_pkg::CSR_FILTER_GAIN, evema_pkg::GAIN_RESET);
            end
            default: begin
               write_csr(evema_pkg::CSR_COUNTS_PER_REV, 17'($urandom_range(65535)));
               write_csr(evema_pkg::CSR_FILTER_GAIN, 17'($urandom_range(131071)));
            end
         endcase
         no_gaps = (phase == 3);
         for (int n = 0; n < 150; n++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               case ($urandom_range(3))
                  0: stamp = stamp + 63'($urandom_range(1, 100));
                  1: stamp = stamp + 63'($urandom_range(1, 20000));
                  2: stamp = stamp + 63'($urandom_range(1, 2000000));
                  default: stamp = stamp + 63'($urandom);
               endcase
               if ($urandom_range(3) == 0) count = count + $urandom;
               else count = count + $urandom_range(4000) - 32'd2000;
            end else if (pick < 80) begin
               stamp = stamp - 63'($urandom_range(3));
               count = count + $urandom_range(200) - 32'd100;
            end else if (pick < 90) begin
               stamp = stamp + 63'($urandom_range(1, 5000));
               count = $urandom;
            end else begin
               stamp = 63'({$urandom, $urandom});
               count = $urandom;
            end
            send_sample(stamp, count);
         end
         no_gaps = 1'b0;
         drain();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_corner_beats();
      test_register_extremes();
      test_random_motion();
      drain();
      if (failures == 0) $display("encoder_velocity_ema_tb: PASS");
      else $display("encoder_velocity_ema_tb: FAIL");
      $finish;
   end

   initial begin
      #10ms;
      $display("encoder_velocity_ema_tb: FAIL");
      $finish;
   end

endmodule
